[rtl/diff_drive_odometry_core_macros.svh]
// Assertion macros shared by the odometry RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH

// same-cycle implication, reset-gated
`define DDO_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-gated
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ddo_pkg.sv]
// Package for the differential-drive odometry core: constants, state type,
// CORDIC arctangent table and small helpers. No dependencies.
package ddo_pkg;

    localparam int CORDIC_ITER_DEFAULT = 16;
    localparam int CORDIC_ITER_MAX     = 32;
    localparam int PADDR_W             = 3;
    localparam int DIVW                = 38;

    localparam logic [2:0]  REG_WHEEL_BASE   = 3'd0;
    localparam logic [11:0] WHEEL_BASE_RESET = 12'd500;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic [25:0] ANGLE_RATE_Q16   = 26'd44798134;
    localparam logic [9:0]  MILLI            = 10'd1000;

    typedef enum logic [4:0] {
        S_IDLE, S_ROT, S_TRIG, S_MS,
        S_PX_LO, S_PX_HI, S_PX_UPD,
        S_PY_LO, S_PY_HI, S_PY_UPD,
        S_MD, S_DIV, S_RK, S_QLO, S_QHI, S_HEAD, S_AM, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_MD, DIV_FRAC, DIV_ANG
    } div_sel_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // clamp a CORDIC output to +-1.0 in Q1.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh040000000)
            r = 32'sh40000000;
        else if (v < -34'sh040000000)
            r = -32'sh40000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/diff_drive_odometry_core.sv]
// Differential-drive odometry core: sequenced Euler pose integrator.
// Depends on ddo_pkg and diff_drive_odometry_core_macros.svh.
`include "diff_drive_odometry_core_macros.svh"

// One request runs from acceptance to the next acceptance through two passes
// of the shared CORDIC rotator, three passes of the 38-step restoring divider,
// a handful of multiply/accumulate steps on the shared 21x31 multiplier, a
// result state and an idle state. out_stall holds the result state. in_stall
// is high from acceptance until the result request is taken. The position
// moves along the heading held before the request; the heading then advances.
// wheel_base_mm sits at byte address 0 of the APB port; a value of zero acts
// as 1 mm.
module diff_drive_odometry_core #(
    parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ddo_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [15:0]           left_speed,
    input  logic signed [15:0]           right_speed,
    input  logic [19:0]                  elapsed_us,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [47:0]           x_position,
    output logic signed [47:0]           y_position,
    output logic signed [15:0]           heading_angle,
    output logic signed [15:0]           linear_speed,
    output logic signed [26:0]           angular_speed,
    output logic signed [15:0]           quat_z,
    output logic [14:0]                  quat_w
);
    import ddo_pkg::*;

    localparam int ITER_EFF = (CORDIC_ITERATIONS > CORDIC_ITER_MAX) ?
                              CORDIC_ITER_MAX : CORDIC_ITERATIONS;
    localparam logic [4:0] ITER_LAST = 5'(ITER_EFF - 1);
    localparam logic [5:0] DIV_LAST  = 6'(DIVW - 1);

    state_t   state_reg, state_next;
    div_sel_t dsel_reg, dsel_next;

    logic [11:0]        wb_reg;
    logic [47:0]        pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0]        heading_reg, heading_next;
    logic signed [16:0] sum_reg, sum_next, diff_reg, diff_next;
    logic [19:0]        dt_reg, dt_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] cz_reg, cz_next;
    logic [4:0]         iter_reg, iter_next;
    logic               pass_reg, pass_next, flip_reg, flip_next;
    logic signed [31:0] cos_reg, cos_next, sin_reg, sin_next;
    logic [36:0]        ms_reg, ms_next, q_reg, q_next;
    logic [52:0]        acc_reg, acc_next;
    logic [37:0]        dvd_reg, dvd_next;
    logic [11:0]        drem_reg, drem_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic signed [26:0] ang_reg, ang_next;
    logic signed [15:0] lin_reg, lin_next, qz_reg, qz_next;
    logic [14:0]        qw_reg, qw_next;

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_WHEEL_BASE) ? {20'd0, wb_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_reg <= WHEEL_BASE_RESET;
        else if (cfg_wr && paddr == REG_WHEEL_BASE)
            wb_reg <= pwdata[11:0];
    end

    logic [11:0] wb_eff;
    assign wb_eff = (wb_reg == 12'd0) ? 12'd1 : wb_reg;

    // magnitudes
    logic [16:0] abs_sum, abs_diff;
    logic [30:0] abs_trig;
    logic        trig_neg;
    assign abs_sum  = sum_reg[16]  ? 17'(-sum_reg)  : 17'(sum_reg);
    assign abs_diff = diff_reg[16] ? 17'(-diff_reg) : 17'(diff_reg);
    always_comb
    begin
        if (state_reg == S_PY_LO || state_reg == S_PY_HI || state_reg == S_PY_UPD)
            trig_neg = sin_reg[31];
        else
            trig_neg = cos_reg[31];
        if (state_reg == S_PY_LO || state_reg == S_PY_HI)
            abs_trig = sin_reg[31] ? 31'(-sin_reg) : 31'(sin_reg);
        else
            abs_trig = cos_reg[31] ? 31'(-cos_reg) : 31'(cos_reg);
    end

    // shared multiplier
    logic [20:0] mul_a;
    logic [30:0] mul_b;
    logic [51:0] mul_p;
    always_comb
    begin
        case (state_reg)
            S_MS:             begin mul_a = {4'd0, abs_sum};     mul_b = {11'd0, dt_reg}; end
            S_PX_LO, S_PY_LO: begin mul_a = {5'd0, ms_reg[15:0]}; mul_b = abs_trig; end
            S_PX_HI, S_PY_HI: begin mul_a = ms_reg[36:16];        mul_b = abs_trig; end
            S_MD:             begin mul_a = {4'd0, abs_diff};    mul_b = {11'd0, dt_reg}; end
            S_RK:             begin mul_a = {9'd0, drem_reg};    mul_b = {5'd0, ANGLE_RATE_Q16}; end
            S_QLO:            begin mul_a = q_reg[20:0];         mul_b = {5'd0, ANGLE_RATE_Q16}; end
            S_QHI:            begin mul_a = {5'd0, q_reg[36:21]}; mul_b = {5'd0, ANGLE_RATE_Q16}; end
            S_AM:             begin mul_a = {4'd0, abs_diff};    mul_b = {21'd0, MILLI}; end
            default:          begin mul_a = '0;                  mul_b = '0; end
        endcase
    end
    assign mul_p = 52'(mul_a) * 52'(mul_b);

    // divider step
    logic [12:0] trial;
    logic        div_ge;
    logic [11:0] rem_new;
    logic [37:0] quot_new;
    assign trial    = {drem_reg, dvd_reg[37]};
    assign div_ge   = trial >= {1'b0, wb_eff};
    assign rem_new  = div_ge ? 12'(trial - {1'b0, wb_eff}) : trial[11:0];
    assign quot_new = {dvd_reg[36:0], div_ge};

    // CORDIC step
    logic signed [33:0] dx, dy, xf, yf;
    logic signed [32:0] at;
    assign dx = cy_reg >>> iter_reg;
    assign dy = cx_reg >>> iter_reg;
    assign at = $signed({1'b0, atan_entry(iter_reg)});
    assign xf = flip_reg ? -cx_reg : cx_reg;
    assign yf = flip_reg ? -cy_reg : cy_reg;

    // move step and heading helpers
    logic [47:0]        move_d;
    logic [31:0]        dh;
    logic signed [32:0] half_h;
    logic signed [31:0] cf, sf;
    logic signed [33:0] qz_t, qw_t;
    assign move_d = {10'd0, acc_reg[52:15]};
    assign dh     = acc_reg[47:16];
    assign half_h = ($signed({heading_reg[31], heading_reg}) +
                     $signed({32'd0, heading_reg[31]})) >>> 1;
    assign cf     = clamp_q30(xf);
    assign sf     = clamp_q30(yf);
    assign qz_t   = ($signed({{2{sf[31]}}, sf}) + 34'sd16384) >>> 15;
    assign qw_t   = ($signed({{2{cf[31]}}, cf}) + 34'sd16384) >>> 15;

    logic signed [16:0] in_sum;
    logic [31:0]        load_ang;
    assign in_sum = $signed({left_speed[15], left_speed}) +
                    $signed({right_speed[15], right_speed});

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        dsel_next    = dsel_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        sum_next     = sum_reg;
        diff_next    = diff_reg;
        dt_next      = dt_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        iter_next    = iter_reg;
        pass_next    = pass_reg;
        flip_next    = flip_reg;
        cos_next     = cos_reg;
        sin_next     = sin_reg;
        ms_next      = ms_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        dvd_next     = dvd_reg;
        drem_next    = drem_reg;
        dcnt_next    = dcnt_reg;
        ang_next     = ang_reg;
        lin_next     = lin_reg;
        qz_next      = qz_reg;
        qw_next      = qw_reg;
        load_ang     = heading_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sum_next  = in_sum;
                    diff_next = $signed({right_speed[15], right_speed}) -
                                $signed({left_speed[15], left_speed});
                    dt_next   = elapsed_us;
                    lin_next  = 16'((in_sum + $signed({16'd0, in_sum[16]})) >>> 1);
                    load_ang  = heading_reg;
                    flip_next = load_ang[31] ^ load_ang[30];
                    cx_next   = CORDIC_GAIN_Q30;
                    cy_next   = '0;
                    cz_next   = $signed({load_ang[31] ^ flip_next, load_ang[31] ^ flip_next,
                                         load_ang[30:0]});
                    iter_next = '0;
                    pass_next = 1'b0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (!cz_reg[32])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + at;
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == ITER_LAST)
                    state_next = S_TRIG;
            end
            S_TRIG:
            begin
                if (!pass_reg)
                begin
                    cos_next   = cf;
                    sin_next   = sf;
                    state_next = S_MS;
                end
                else
                begin
                    qz_next = (qz_t > 34'sd32767) ? 16'sh7FFF : 16'(qz_t);
                    if (qw_t > 34'sd32767)
                        qw_next = 15'h7FFF;
                    else if (qw_t < 34'sd0)
                        qw_next = 15'd0;
                    else
                        qw_next = 15'(qw_t);
                    state_next = S_OUT;
                end
            end
            S_MS:
            begin
                ms_next    = mul_p[36:0];
                state_next = S_PX_LO;
            end
            S_PX_LO, S_PY_LO:
            begin
                acc_next   = {22'd0, mul_p[46:16]};
                state_next = (state_reg == S_PX_LO) ? S_PX_HI : S_PY_HI;
            end
            S_PX_HI, S_PY_HI:
            begin
                acc_next   = {1'b0, mul_p} + acc_reg;
                state_next = (state_reg == S_PX_HI) ? S_PX_UPD : S_PY_UPD;
            end
            S_PX_UPD:
            begin
                pos_x_next = (sum_reg[16] ^ trig_neg) ? pos_x_reg - move_d
                                                      : pos_x_reg + move_d;
                state_next = S_PY_LO;
            end
            S_PY_UPD:
            begin
                pos_y_next = (sum_reg[16] ^ trig_neg) ? pos_y_reg - move_d
                                                      : pos_y_reg + move_d;
                state_next = S_MD;
            end
            S_MD, S_RK, S_AM:
            begin
                dvd_next  = mul_p[37:0];
                drem_next = '0;
                dcnt_next = '0;
                if (state_reg == S_MD)
                    dsel_next = DIV_MD;
                else if (state_reg == S_RK)
                    dsel_next = DIV_FRAC;
                else
                    dsel_next = DIV_ANG;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dvd_next  = quot_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == DIV_LAST)
                begin
                    case (dsel_reg)
                        DIV_MD:
                        begin
                            q_next     = quot_new[36:0];
                            state_next = S_RK;
                        end
                        DIV_FRAC:
                        begin
                            acc_next   = {15'd0, quot_new};
                            state_next = S_QLO;
                        end
                        DIV_ANG:
                        begin
                            ang_next  = diff_reg[16] ? -27'(quot_new) : 27'(quot_new);
                            load_ang  = half_h[31:0];
                            flip_next = load_ang[31] ^ load_ang[30];
                            cx_next   = CORDIC_GAIN_Q30;
                            cy_next   = '0;
                            cz_next   = $signed({load_ang[31] ^ flip_next,
                                                 load_ang[31] ^ flip_next, load_ang[30:0]});
                            iter_next = '0;
                            pass_next = 1'b1;
                            state_next = S_ROT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_QLO:
            begin
                acc_next   = acc_reg + {1'b0, mul_p};
                state_next = S_QHI;
            end
            S_QHI:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 21'd0};
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                heading_next = diff_reg[16] ? heading_reg - dh : heading_reg + dh;
                state_next   = S_AM;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dsel_reg <= dsel_next;
        sum_reg  <= sum_next;
        diff_reg <= diff_next;
        dt_reg   <= dt_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        iter_reg <= iter_next;
        pass_reg <= pass_next;
        flip_reg <= flip_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        ms_reg   <= ms_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        dcnt_reg <= dcnt_next;
        ang_reg  <= ang_next;
        lin_reg  <= lin_next;
        qz_reg   <= qz_next;
        qw_reg   <= qw_next;
    end

    // ports
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign x_position    = pos_x_reg;
    assign y_position    = pos_y_reg;
    assign heading_angle = heading_reg[31:16];
    assign linear_speed  = lin_reg;
    assign angular_speed = ang_reg;
    assign quat_z        = qz_reg;
    assign quat_w        = qw_reg;

    // checks
    `DDO_ASSERT_IMPLY(a_no_accept_while_result, out_valid, in_stall, "request accepted while result pending")
    `DDO_ASSERT_NEXT(a_result_taken_idle, out_valid && !out_stall, !out_valid && !in_stall, "sequencer did not return to idle")
    `DDO_ASSERT_IMPLY(a_div_count_range, state_reg == S_DIV, dcnt_reg <= DIV_LAST, "divider count overran")
    `DDO_ASSERT_IMPLY(a_pose_stable_out, out_valid && $past(out_valid), $stable(pos_x_reg) && $stable(heading_reg), "pose changed during result")

endmodule
